// ===== src/itf_pkg.sv =====
// Shared constants for the integer-to-text formatter: request kinds,
// ASCII codes, pointer width and the digit-to-character helper.
// No dependencies.
package itf_pkg;

  // Request kinds
  localparam logic [2:0] KIND_SDEC = 3'd0;
  localparam logic [2:0] KIND_UDEC = 3'd1;
  localparam logic [2:0] KIND_OCT  = 3'd2;
  localparam logic [2:0] KIND_HEX  = 3'd3;
  localparam logic [2:0] KIND_PTR  = 3'd4;
  localparam logic [2:0] KIND_CHAR = 3'd5;

  // Pointer width, 32..64
  localparam int unsigned POINTER_BITS = 64;
  localparam logic [63:0] PTR_MASK = {64{1'b1}} >> (64 - POINTER_BITS);

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOWA  = 8'h61;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_RPAR  = 8'h29;

  // Text strings, first character in the top byte
  localparam logic [39:0] TXT_NIL  = {CH_LPAR, CH_N, CH_I, CH_L, CH_RPAR};
  localparam logic [39:0] TXT_HEX  = {CH_ZERO, CH_X, 24'h0};
  localparam logic [39:0] TXT_NEG  = {CH_MINUS, 32'h0};

  // Bit and digit counts per kind
  localparam logic [5:0] DEC_BITS   = 6'd32;
  localparam logic [5:0] DEC_DIGITS = 6'd10;
  localparam logic [5:0] OCT_DIGITS = 6'd11;
  localparam logic [5:0] HEX_DIGITS = 6'd8;
  localparam logic [5:0] PTR_DIGITS = 6'd16;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d > 4'd9) begin
      c = CH_LOWA + {4'd0, d} - 8'd10;
    end else begin
      c = CH_ZERO + {4'd0, d};
    end
    return c;
  endfunction

endpackage

// ===== src/integer_to_text_formatter_core.sv =====
// Integer-to-text formatter top level: sequencer, double-dabble unit and
// digit shifter in one module.
// Depends on itf_pkg.
//
//  channel   direction  ports                                  handshake
//  request   in         req_type_i, value_i                    start_i & !busy_o
//  text      out        text_char_o, last_char_o               char_valid_o
//
// Octal and hex step one digit position per cycle (11 or 8); pointer sends the "0x"
// prefix and 16 digit positions, or the five characters of "(nil)"; character sends
// one. Decimal first runs the shared double-dabble unit over all 32 input bits, then
// a minus sign when negative, then 10 digit positions. Leading zero positions are
// stepped through without output; each character leaves in the cycle after its step.
// Reset clears the sequencer; busy_o is high while it runs. The receiver cannot stall.
module integer_to_text_formatter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  req_type_i,
  input  logic [63:0] value_i,
  output logic        char_valid_o,
  output logic [7:0]  text_char_o,
  output logic        last_char_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_TEXT = 2'd2;
  localparam logic [1:0] ST_DIGS = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] dig_q, dig_d;
  logic [31:0] bin_q, bin_d;
  logic [39:0] txt_q, txt_d;
  logic [2:0]  tcnt_q, tcnt_d;
  logic        tlast_q, tlast_d;
  logic        neg_q, neg_d;
  logic        rad3_q, rad3_d;
  logic        lead_q, lead_d;
  logic        vld_d;
  logic [7:0]  chr_d;
  logic        lst_d;

  logic [31:0] low32;
  logic [63:0] ptr;
  logic [39:0] bcd_adj;
  logic [3:0]  top;

  assign low32 = value_i[31:0];
  assign ptr   = value_i & itf_pkg::PTR_MASK;
  assign top   = rad3_q ? {1'b0, dig_q[63:61]} : dig_q[63:60];

  // Add 3 to every BCD nibble of five or more before the shift
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      if (dig_q[24 + 4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = dig_q[24 + 4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = dig_q[24 + 4*i +: 4];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    dig_d   = dig_q;
    bin_d   = bin_q;
    txt_d   = txt_q;
    tcnt_d  = tcnt_q;
    tlast_d = tlast_q;
    neg_d   = neg_q;
    rad3_d  = rad3_q;
    lead_d  = lead_q;
    vld_d   = 1'b0;
    chr_d   = 8'h00;
    lst_d   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          rad3_d = 1'b0;
          lead_d = 1'b1;
          neg_d  = 1'b0;
          unique case (req_type_i) inside
            itf_pkg::KIND_SDEC, itf_pkg::KIND_UDEC: begin
              if (req_type_i == itf_pkg::KIND_SDEC && low32[31]) begin
                neg_d = 1'b1;
                bin_d = 32'd0 - low32;
              end else begin
                bin_d = low32;
              end
              dig_d   = 64'd0;
              cnt_d   = itf_pkg::DEC_BITS;
              state_d = ST_CONV;
            end
            itf_pkg::KIND_OCT: begin
              dig_d   = {1'b0, low32, 31'd0};
              cnt_d   = itf_pkg::OCT_DIGITS;
              rad3_d  = 1'b1;
              state_d = ST_DIGS;
            end
            itf_pkg::KIND_HEX: begin
              dig_d   = {low32, 32'd0};
              cnt_d   = itf_pkg::HEX_DIGITS;
              state_d = ST_DIGS;
            end
            itf_pkg::KIND_PTR: begin
              if (ptr == 64'd0) begin
                txt_d   = itf_pkg::TXT_NIL;
                tcnt_d  = 3'd5;
                tlast_d = 1'b1;
              end else begin
                txt_d   = itf_pkg::TXT_HEX;
                tcnt_d  = 3'd2;
                tlast_d = 1'b0;
                dig_d   = ptr;
                cnt_d   = itf_pkg::PTR_DIGITS;
              end
              state_d = ST_TEXT;
            end
            itf_pkg::KIND_CHAR: begin
              txt_d   = {value_i[7:0], 32'd0};
              tcnt_d  = 3'd1;
              tlast_d = 1'b1;
              state_d = ST_TEXT;
            end
            default: begin
              // unused kinds: drop the request
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_CONV: begin
        dig_d = {bcd_adj[38:0], bin_q[31], 24'd0};
        bin_d = {bin_q[30:0], 1'b0};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          cnt_d = itf_pkg::DEC_DIGITS;
          if (neg_q) begin
            txt_d   = itf_pkg::TXT_NEG;
            tcnt_d  = 3'd1;
            tlast_d = 1'b0;
            state_d = ST_TEXT;
          end else begin
            state_d = ST_DIGS;
          end
        end
      end
      ST_TEXT: begin
        vld_d  = 1'b1;
        chr_d  = txt_q[39:32];
        lst_d  = tlast_q && (tcnt_q == 3'd1);
        txt_d  = {txt_q[31:0], 8'd0};
        tcnt_d = tcnt_q - 3'd1;
        if (tcnt_q == 3'd1) begin
          state_d = tlast_q ? ST_IDLE : ST_DIGS;
        end
      end
      ST_DIGS: begin
        // skip leading zeros but always keep the last position
        if (!lead_q || top != 4'd0 || cnt_q == 6'd1) begin
          vld_d  = 1'b1;
          chr_d  = itf_pkg::digit_char(top);
          lst_d  = (cnt_q == 6'd1);
          lead_d = 1'b0;
        end
        dig_d = rad3_q ? {dig_q[60:0], 3'd0} : {dig_q[59:0], 4'd0};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      char_valid_o <= 1'b0;
    end else begin
      state_q      <= state_d;
      char_valid_o <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q       <= cnt_d;
    dig_q       <= dig_d;
    bin_q       <= bin_d;
    txt_q       <= txt_d;
    tcnt_q      <= tcnt_d;
    tlast_q     <= tlast_d;
    neg_q       <= neg_d;
    rad3_q      <= rad3_d;
    lead_q      <= lead_d;
    text_char_o <= chr_d;
    last_char_o <= lst_d;
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ===== dv/integer_to_text_formatter_core_tb.sv =====
// Self-checking testbench for integer_to_text_formatter_core: directed and random conversion
// requests, each expected string typed in or computed in-bench and compared per character.
// Depends on itf_pkg and the core RTL.
module integer_to_text_formatter_core_tb;

  localparam logic [2:0]  KIND_UNUSED_LO = 3'd6;
  localparam logic [2:0]  KIND_UNUSED_HI = 3'd7;
  localparam logic [63:0] RADIX_OCT      = 64'd8;
  localparam logic [63:0] RADIX_DEC      = 64'd10;
  localparam logic [63:0] RADIX_HEX      = 64'd16;
  localparam int          RANDOM_ITEMS   = 125;
  localparam int          DRAIN_CYCLES   = 100;
  localparam int          WATCHDOG_LIMIT = 1000;

  typedef logic [7:0] text_t[$];

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
  } text_char_t;

  typedef struct {
    logic [2:0]  kind;
    logic [63:0] value;
    string       text;
    bit          typed;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        start_i     = 1'b0;
  logic [2:0]  req_type_i  = '0;
  logic [63:0] value_i     = '0;
  logic        busy_o;
  logic        char_valid_o;
  logic [7:0]  text_char_o;
  logic        last_char_o;

  text_char_t  pending_chars[$];
  int          fail_count    = 0;
  int          chars_checked = 0;
  int          stall_cycles  = 0;
  int          kind_count[8];

  // Rows with typed text are checked against that text; the rest go through format_request.
  stim_row_t dir_rows[] = '{
    '{itf_pkg::KIND_SDEC, 64'd0,                    "0",           1'b1},
    '{itf_pkg::KIND_SDEC, 64'd1,                    "1",           1'b1},
    '{itf_pkg::KIND_SDEC, 64'h7FFF_FFFF,            "2147483647",  1'b1},
    '{itf_pkg::KIND_SDEC, 64'h8000_0000,            "-2147483648", 1'b1},
    '{itf_pkg::KIND_SDEC, 64'hFFFF_FFFF,            "-1",          1'b1},
    '{itf_pkg::KIND_SDEC, 64'hFFFF_FFFF_0000_0005,  "5",           1'b1},
    '{itf_pkg::KIND_UDEC, 64'd0,                    "0",           1'b1},
    '{itf_pkg::KIND_UDEC, 64'hFFFF_FFFF,            "4294967295",  1'b1},
    '{itf_pkg::KIND_UDEC, 64'h1234_5678_9ABC_DEF0,  "",            1'b0},
    '{itf_pkg::KIND_OCT,  64'd0,                    "0",           1'b1},
    '{itf_pkg::KIND_OCT,  64'hFFFF_FFFF,            "37777777777", 1'b1},
    '{itf_pkg::KIND_OCT,  64'd8,                    "10",          1'b1},
    '{itf_pkg::KIND_HEX,  64'd0,                    "0",           1'b1},
    '{itf_pkg::KIND_HEX,  64'hFFFF_FFFF,            "ffffffff",    1'b1},
    '{itf_pkg::KIND_HEX,  64'hFEDC_BA98_0A1B_2C3D,  "",            1'b0},
    '{itf_pkg::KIND_PTR,  64'd0,                    "(nil)",       1'b1},
    '{itf_pkg::KIND_PTR,  64'd1,                    "0x1",         1'b1},
    '{itf_pkg::KIND_PTR,  64'hFFFF_FFFF_FFFF_FFFF,  "",            1'b0},
    '{itf_pkg::KIND_PTR,  64'h8000_0000_0000_0000,  "",            1'b0},
    '{itf_pkg::KIND_PTR,  64'h0000_0001_0000_0000,  "",            1'b0},
    '{itf_pkg::KIND_CHAR, 64'h41,                   "A",           1'b1},
    '{itf_pkg::KIND_CHAR, 64'd0,                    "",            1'b0},
    '{itf_pkg::KIND_CHAR, 64'hFFFF_FFFF_FFFF_FFFF,  "",            1'b0},
    '{KIND_UNUSED_LO, 64'h1234,            "",            1'b1},
    '{KIND_UNUSED_HI, 64'hFFFF_FFFF_FFFF_FFFF, "",        1'b1}
  };

  integer_to_text_formatter_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .value_i      (value_i),
    .char_valid_o (char_valid_o),
    .text_char_o  (text_char_o),
    .last_char_o  (last_char_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic text_t text_of(input string s);
    text_t txt;
    for (int i = 0; i < s.len(); i++) begin
      txt.push_back(s[i]);
    end
    return txt;
  endfunction

  // Build digits most significant first; zero gives a single '0'.
  function automatic text_t digits_of(input logic [63:0] mag, input logic [63:0] radix);
    text_t       txt;
    logic [63:0] rest;
    logic [63:0] d;
    rest = mag;
    if (rest == 64'd0) begin
      txt.push_back(itf_pkg::CH_ZERO);
    end
    while (rest != 64'd0) begin
      d = rest % radix;
      txt.push_front(d > 64'd9 ? itf_pkg::CH_LOWA + d[7:0] - 8'd10
                               : itf_pkg::CH_ZERO + d[7:0]);
      rest = rest / radix;
    end
    return txt;
  endfunction

  function automatic text_t format_request(input logic [2:0] kind, input logic [63:0] value);
    text_t       txt;
    logic [31:0] low_word;
    logic [63:0] ptr;
    low_word = value[31:0];
    ptr      = value & itf_pkg::PTR_MASK;
    case (kind)
      itf_pkg::KIND_SDEC: begin
        if (low_word[31]) begin
          txt = digits_of(64'h1_0000_0000 - {32'd0, low_word}, RADIX_DEC);
          txt.push_front(itf_pkg::CH_MINUS);
        end else begin
          txt = digits_of({32'd0, low_word}, RADIX_DEC);
        end
      end
      itf_pkg::KIND_UDEC: txt = digits_of({32'd0, low_word}, RADIX_DEC);
      itf_pkg::KIND_OCT:  txt = digits_of({32'd0, low_word}, RADIX_OCT);
      itf_pkg::KIND_HEX:  txt = digits_of({32'd0, low_word}, RADIX_HEX);
      itf_pkg::KIND_PTR: begin
        if (ptr == 64'd0) begin
          txt = text_of("(nil)");
        end else begin
          txt = digits_of(ptr, RADIX_HEX);
          txt.push_front(itf_pkg::CH_X);
          txt.push_front(itf_pkg::CH_ZERO);
        end
      end
      itf_pkg::KIND_CHAR: txt.push_back(value[7:0]);
      default: ;
    endcase
    return txt;
  endfunction

  function automatic void expect_text(input text_t txt);
    foreach (txt[i]) begin
      pending_chars.push_back(text_char_t'{ch: txt[i], is_last: (i == txt.size() - 1)});
    end
  endfunction

  // Hold start high across back-to-back requests; drop it only for a gap.
  task automatic send_request(input logic [2:0] kind, input logic [63:0] value, input int gap,
                              input bit typed, input string text);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    req_type_i <= kind;
    value_i    <= value;
    do @(posedge clk_i); while (busy_o);
    expect_text(typed ? text_of(text) : format_request(kind, value));
    kind_count[kind]++;
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(0, 6))
      0: v = {$urandom, $urandom};
      1: v = 64'($urandom_range(0, 20));
      2: v = {32'd0, $urandom};
      3: v = {$urandom, 32'd0} | 64'($urandom_range(0, 1));
      4: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      5: v = {$urandom, $urandom >> $urandom_range(0, 31)};
      default: begin
        case ($urandom_range(0, 5))
          0: v = 64'd0;
          1: v = 64'h8000_0000;
          2: v = 64'hFFFF_FFFF;
          3: v = 64'h7FFF_FFFF;
          4: v = 64'hFFFF_FFFF_FFFF_FFFF;
          default: v = 64'h8000_0000_0000_0000;
        endcase
      end
    endcase
    return v;
  endfunction

  always @(posedge clk_i) begin : check_text
    text_char_t want;
    if (rst_ni && char_valid_o) begin
      if (pending_chars.size() == 0) begin
        $error("text_char: none expected, got %h (last_char %b)", text_char_o, last_char_o);
        fail_count++;
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (text_char_o !== want.ch) begin
          $error("text_char mismatch: expected %h, got %h", want.ch, text_char_o);
          fail_count++;
        end
        if (last_char_o !== want.is_last) begin
          $error("last_char mismatch: expected %b, got %b", want.is_last, last_char_o);
          fail_count++;
        end
      end
    end
  end

  // End the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || char_valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int          sent;
    int          gap;
    bit          drained;
    logic [2:0]  kind;
    sent    = 0;
    drained = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].kind, dir_rows[i].value, $urandom_range(0, 9),
                   dir_rows[i].typed, dir_rows[i].text);
    end

    while (sent < RANDOM_ITEMS) begin
      if (sent == 100 && !drained) begin
        // let every pending transaction finish before the next request
        start_i <= 1'b0;
        while (pending_chars.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
        drained = 1'b1;
      end
      gap = (sent >= 50 && sent < 80) ? 0 : $urandom_range(0, 9);
      if ($urandom_range(0, 11) == 0) begin
        kind = $urandom_range(0, 1) ? KIND_UNUSED_HI : KIND_UNUSED_LO;
      end else begin
        kind = 3'($urandom_range(0, 5));
        sent++;
      end
      send_request(kind, pick_value(), gap, 1'b0, "");
    end

    start_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Requests: sdec %0d, udec %0d, oct %0d, hex %0d, ptr %0d, char %0d, unused %0d",
             kind_count[itf_pkg::KIND_SDEC], kind_count[itf_pkg::KIND_UDEC],
             kind_count[itf_pkg::KIND_OCT], kind_count[itf_pkg::KIND_HEX],
             kind_count[itf_pkg::KIND_PTR], kind_count[itf_pkg::KIND_CHAR],
             kind_count[KIND_UNUSED_LO] + kind_count[KIND_UNUSED_HI]);
    $display("Characters checked: %0d, mismatches: %0d", chars_checked, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
